@@ design/kwsm_pkg.sv @@
// Package: shared constants and status codes for the k-way sorted merge.
`default_nettype none
package kwsm_pkg;
	localparam int NUM_LISTS_DEF  = 8;
	localparam int LIST_DEPTH_DEF = 64;

	localparam int ACT_W = 1;
	localparam int IDX_W = 3;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;

	typedef enum logic [ST_W-1:0] {
		ST_APPENDED = 2'd0,
		ST_FULL     = 2'd1,
		ST_POPPED   = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	localparam logic [ACT_W-1:0] ACT_APPEND = 1'b0;
	localparam logic [ACT_W-1:0] ACT_POP    = 1'b1;
endpackage
`default_nettype wire

@@ design/k_way_sorted_merge.sv @@
// Top level: k-way merge of ascending lists held in one list memory.
//
// Input channel (in_valid/in_ready) carries one transaction per request:
// action 0 appends value to list list_index, action 1 pops the smallest
// head over all non-empty lists (ties go to the lower list index).
// Output channel (out_valid/out_ready) returns exactly one result per
// request: status, merged_value, source_list.
//
// Append: the result register is loaded at accept.
// Pop: the heads are read from the list memory one list per cycle through
// its single registered read port, and the result is loaded once the scan
// has passed every list.
// One request is in work at a time; in_ready is high only while the block
// is idle and the result register is empty, so the block takes no new
// request before it is through with the last one.
//
// Reset (arst_n low) clears fill counts and head pointers: every list is
// empty. List memory contents are not cleared; only written slots are used.
// When the receiver stalls, the result holds in the output register and no
// new request is taken until it is delivered.
`default_nettype none
module k_way_sorted_merge
	import kwsm_pkg::*;
#(
	parameter int NUM_LISTS  = kwsm_pkg::NUM_LISTS_DEF,
	parameter int LIST_DEPTH = kwsm_pkg::LIST_DEPTH_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire [kwsm_pkg::ACT_W-1:0] action,
	input  wire [kwsm_pkg::IDX_W-1:0] list_index,
	input  wire signed [kwsm_pkg::VAL_W-1:0] value,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic [kwsm_pkg::ST_W-1:0] status,
	output logic signed [kwsm_pkg::VAL_W-1:0] merged_value,
	output logic [kwsm_pkg::IDX_W-1:0] source_list
);
	// widths derived from the parameters
	localparam int PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int FW = $clog2(LIST_DEPTH + 1);
	localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int CW = $clog2(NUM_LISTS + 1);
	localparam int ENTRIES = NUM_LISTS * LIST_DEPTH;
	localparam int AW = $clog2(ENTRIES);
	localparam int XW = (IDX_W > CW) ? IDX_W : CW;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

	state_t              state_q;
	logic [PW-1:0]       rdpos_q [NUM_LISTS];
	logic [FW-1:0]       fill_q  [NUM_LISTS];
	logic [VAL_W-1:0]    mem     [ENTRIES];
	logic [VAL_W-1:0]    rdata_s1;
	logic                hv_s1;
	logic [LW-1:0]       li_s1;
	logic [CW-1:0]       cnt_q;
	logic                found_q;
	logic [LW-1:0]       best_q;
	logic signed [VAL_W-1:0] best_val_q;

	// append path
	logic [LW-1:0]       app_li;
	logic                app_bad;
	logic [PW:0]         tail_sum;
	logic [PW-1:0]       tail_slot;
	logic [AW-1:0]       wr_addr;
	logic                accept;

	// scan path
	logic [LW-1:0]       scan_li;
	logic [AW-1:0]       rd_addr;
	logic                cmp_take;

	assign in_ready = (state_q == S_IDLE) && !out_valid;
	assign accept   = in_valid && in_ready;

	always_comb begin
		app_li   = list_index[LW-1:0];
		if (LW > IDX_W) app_li = LW'(list_index);
		app_bad  = (XW'(list_index) >= XW'(NUM_LISTS)) ||
			(fill_q[app_li] >= FW'(LIST_DEPTH));
		tail_sum = (PW+1)'(rdpos_q[app_li]) + (PW+1)'(fill_q[app_li]);
		// sum stays below twice the depth: one compare and subtract
		if (tail_sum >= (PW+1)'(LIST_DEPTH)) tail_sum = tail_sum - (PW+1)'(LIST_DEPTH);
		tail_slot = tail_sum[PW-1:0];
		wr_addr  = AW'(app_li) * AW'(LIST_DEPTH) + AW'(tail_slot);
		scan_li  = cnt_q[LW-1:0];
		rd_addr  = AW'(scan_li) * AW'(LIST_DEPTH) + AW'(rdpos_q[scan_li]);
		cmp_take = hv_s1 && (!found_q || ($signed(rdata_s1) < best_val_q));
	end

	// list memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && action == ACT_APPEND && !app_bad) begin
			mem[wr_addr] <= value;
		end
		rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			hv_s1     <= 1'b0;
			cnt_q     <= '0;
			found_q   <= 1'b0;
			for (int i = 0; i < NUM_LISTS; i++) begin
				rdpos_q[i] <= '0;
				fill_q[i]  <= '0;
			end
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					hv_s1 <= 1'b0;
					if (accept) begin
						if (action == ACT_APPEND) begin
							out_valid    <= 1'b1;
							merged_value <= '0;
							source_list  <= '0;
							if (app_bad) begin
								status <= ST_FULL;
							end else begin
								status <= ST_APPENDED;
								fill_q[app_li] <= fill_q[app_li] + FW'(1);
							end
						end else begin
							state_q <= S_SCAN;
							cnt_q   <= '0;
							found_q <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					if (cnt_q < CW'(NUM_LISTS)) begin
						hv_s1 <= (fill_q[scan_li] != '0);
						li_s1 <= scan_li;
						cnt_q <= cnt_q + CW'(1);
					end else begin
						hv_s1   <= 1'b0;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					hv_s1     <= 1'b0;
					state_q   <= S_IDLE;
					out_valid <= 1'b1;
					if (found_q) begin
						status       <= ST_POPPED;
						merged_value <= best_val_q;
						source_list  <= IDX_W'(best_q);
						fill_q[best_q] <= fill_q[best_q] - FW'(1);
						if (rdpos_q[best_q] == PW'(LIST_DEPTH - 1))
							rdpos_q[best_q] <= '0;
						else
							rdpos_q[best_q] <= rdpos_q[best_q] + PW'(1);
					end else begin
						status       <= ST_EMPTY;
						merged_value <= '0;
						source_list  <= '0;
					end
				end
				default: begin
					hv_s1   <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
			// running minimum over the heads as they come out of memory
			if (cmp_take) begin
				found_q    <= 1'b1;
				best_q     <= li_s1;
				best_val_q <= $signed(rdata_s1);
			end
		end
	end
endmodule
`default_nettype wire

@@ design/kwsm_checker.sv @@
// Checker: port-level assertions for the k-way sorted merge, with bind.
`default_nettype none
module kwsm_checker
	import kwsm_pkg::*;
(
	input wire                       clk,
	input wire                       arst_n,
	input wire                       in_valid,
	input wire                       in_ready,
	input wire                       out_valid,
	input wire                       out_ready,
	input wire [kwsm_pkg::ST_W-1:0]  status,
	input wire [kwsm_pkg::VAL_W-1:0] merged_value,
	input wire [kwsm_pkg::IDX_W-1:0] source_list
);
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(merged_value))
		else $error("stalled result changed");

	// fields are zero unless a value was popped
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_POPPED |-> merged_value == '0 && source_list == '0)
		else $error("nonzero fields without pop");

	// one request at a time: no accept right after an accept
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");

	// no new request while a result is still pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request taken with result pending");
endmodule

bind k_way_sorted_merge kwsm_checker u_kwsm_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.merged_value(merged_value), .source_list(source_list)
);
`default_nettype wire

@@ dv/k_way_sorted_merge_tb.sv @@
// Testbench for the k-way sorted merge: directed and random appends and pops checked against a list model.
`timescale 1ns / 100ps
`default_nettype none
module k_way_sorted_merge_tb;
	import kwsm_pkg::*;

	localparam int NL = NUM_LISTS_DEF;
	localparam int LD = LIST_DEPTH_DEF;

	// expected result of one transaction
	typedef struct packed {
		logic [ST_W-1:0]  st;
		logic [VAL_W-1:0] val;
		logic [IDX_W-1:0] src;
	} merge_result_t;

	int unsigned mismatch_count = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// list model and queue of expected results
	class merge_scoreboard;
		logic signed [VAL_W-1:0] lists [NL][$];
		merge_result_t pending [$];
		int unsigned pops_seen = 0, fulls_seen = 0, empties_seen = 0;

		function void note_request(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
			logic signed [VAL_W-1:0] v);
			merge_result_t r;
			int best;
			r = '0;
			if (act == ACT_APPEND) begin
				if (idx >= NL || lists[idx].size() >= LD) begin
					r.st = ST_FULL;
				end else begin
					lists[idx].push_back(v);
					r.st = ST_APPENDED;
				end
			end else begin
				best = -1;
				for (int i = 0; i < NL; i++) begin
					if (lists[i].size() != 0) begin
						if (best < 0 || lists[i][0] < lists[best][0]) best = i;
					end
				end
				if (best < 0) begin
					r.st = ST_EMPTY;
				end else begin
					r.st = ST_POPPED;
					r.val = lists[best].pop_front();
					r.src = best[IDX_W-1:0];
				end
			end
			pending.push_back(r);
		endfunction

		task check_result(logic [ST_W-1:0] st, logic [VAL_W-1:0] v,
			logic [IDX_W-1:0] s);
			merge_result_t w;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", {30'd0, st}, 0);
				return;
			end
			w = pending.pop_front();
			if (st != w.st) report_mismatch("status", {30'd0, st}, {30'd0, w.st});
			if (v != w.val) report_mismatch("merged_value", v, w.val);
			if (s != w.src) report_mismatch("source_list", {29'd0, s}, {29'd0, w.src});
			if (w.st == ST_POPPED) pops_seen++;
			if (w.st == ST_FULL) fulls_seen++;
			if (w.st == ST_EMPTY) empties_seen++;
		endtask

		function int total_held();
			int n = 0;
			for (int i = 0; i < NL; i++) n += lists[i].size();
			return n;
		endfunction
	endclass

	logic clk = 1'b0, arst_n = 1'b0;
	logic in_valid = 1'b0, out_ready = 1'b0;
	logic [ACT_W-1:0] action = ACT_APPEND;
	logic [IDX_W-1:0] list_index = '0;
	logic signed [VAL_W-1:0] value = '0;
	wire in_ready, out_valid;
	wire [ST_W-1:0] status;
	wire signed [VAL_W-1:0] merged_value;
	wire [IDX_W-1:0] source_list;

	merge_scoreboard sb = new();
	bit idle_gaps = 1'b1;        // cleared for the last part of the run
	int unsigned long_hold = 0;  // receiver hold-off cycles requested
	logic signed [VAL_W-1:0] tail [NL];  // last value appended per list

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	k_way_sorted_merge u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .list_index(list_index), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .merged_value(merged_value), .source_list(source_list)
	);

	// sample both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_request(action, list_index, value);
		if (arst_n && out_valid && out_ready) sb.check_result(status, merged_value, source_list);
	end

	// receiver: random bursts of stall, plus long hold-offs on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold != 0) begin
				out_ready <= 1'b0;
				repeat (long_hold) @(negedge clk);
				long_hold = 0;
			end else if (idle_gaps && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// offer one transaction and hold it until accepted; valid stays up for a
	// back-to-back follower and drops on an idle gap or in wait_drained
	task automatic send_request(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
		input logic signed [VAL_W-1:0] v);
		if (idle_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		list_index <= idx;
		value <= v;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (act == ACT_APPEND) tail[idx] = v;
	endtask

	// append keeping the list ascending; random step up from the tail
	task automatic append_sorted(input logic [IDX_W-1:0] idx);
		logic signed [VAL_W-1:0] v;
		longint nv;
		if (sb.lists[idx].size() == 0) begin
			v = $urandom();
		end else begin
			nv = longint'(tail[idx]) + $urandom_range(0, 3) * ($urandom_range(0, 1) ? 1 : 1 << 24);
			v = (nv > 64'sh7FFFFFFF) ? 32'sh7FFFFFFF : nv[31:0];
		end
		send_request(ACT_APPEND, idx, v);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	int unsigned sent = 0;

	initial begin
		for (int i = 0; i < NL; i++) tail[i] = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: pop on empty, extremes, ties, unsorted, bit coverage
		send_request(ACT_POP, 3'd5, 32'sh7FFFFFFF);
		send_request(ACT_APPEND, 3'd7, 32'sh80000000);
		send_request(ACT_APPEND, 3'd0, 32'sh7FFFFFFF);
		send_request(ACT_APPEND, 3'd2, 32'sd5);
		send_request(ACT_APPEND, 3'd1, 32'sd5);  // tie with list 2
		send_request(ACT_APPEND, 3'd1, -32'sd9); // unsorted within list 1
		send_request(ACT_APPEND, 3'd4, 32'shFFFFFFFF);
		send_request(ACT_APPEND, 3'd3, 32'sh55555555);
		send_request(ACT_APPEND, 3'd6, 32'shAAAAAAAA);
		repeat (10) send_request(ACT_POP, IDX_W'($urandom()), $urandom());
		sent += 19;
		wait_drained();

		// fill list 3 past its depth while the receiver is held off long
		long_hold = 400;
		for (int k = 0; k < LD + 3; k++) begin
			send_request(ACT_APPEND, 3'd3, k);
			sent++;
		end
		wait_drained();  // sender pauses until every result is back

		// drain and wrap list 3 around its ring
		for (int k = 0; k < LD + 4; k++) begin
			send_request(k % 3 == 2 ? ACT_APPEND : ACT_POP, 3'd3, 1000 + k);
			sent++;
		end

		// random merge traffic: mostly sorted appends and pops, some noise
		while (sent < 680) begin
			if (sent > 600) idle_gaps = 1'b0;
			case ($urandom_range(0, 9))
				0: send_request(ACT_APPEND, IDX_W'($urandom()), $urandom());
				1, 2, 3, 4: append_sorted(IDX_W'($urandom()));
				default: send_request(ACT_POP, IDX_W'($urandom()), $urandom());
			endcase
			sent++;
		end
		while (sb.total_held() != 0) begin
			send_request(ACT_POP, '0, '0);
			sent++;
		end
		send_request(ACT_POP, '0, '0);
		sent++;
		wait_drained();

		$display("Ran %0d transactions: %0d pops, %0d full drops, %0d empty pops.",
			sent, sb.pops_seen, sb.fulls_seen, sb.empties_seen);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d results outstanding", sb.pending.size());
		$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
design/kwsm_pkg.sv
design/k_way_sorted_merge.sv
design/kwsm_checker.sv
dv/k_way_sorted_merge_tb.sv
